@@ hdl/first_fit_block_allocator_macros.svh @@
// Assertion macros for the first-fit block allocator.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int unsigned MaxBlocksDef   = 16;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned AlignBytesDef  = 32;

  localparam int unsigned OffW  = 24;
  localparam int unsigned IdW   = 32;
  localparam int unsigned ExtW  = 28;  // extended offset math, no overflow
  localparam int unsigned DivW  = 25;  // size + align - 1

  localparam logic [OffW-1:0] HeapSizeRst = 24'd1048576;

  localparam logic [2:0] CmdAlloc   = 3'd0;
  localparam logic [2:0] CmdFree    = 3'd1;
  localparam logic [2:0] CmdResolve = 3'd2;
  localparam logic [2:0] CmdPurge   = 3'd3;
  localparam logic [2:0] CmdDefrag  = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSpace  = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_NEED,
    OP_SCAN,
    OP_ALLOC_OK,
    OP_FREE_OK,
    OP_RES_OK,
    OP_RES_REF,
    OP_PURGE,
    OP_DEFRAG,
    OP_FAIL
  } ffba_op_e;

  typedef struct packed {
    ffba_op_e   op;
    logic [1:0] status;
  } ffba_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       gen_match;
    logic       scan_end;
    logic       fit;
    logic       id_hit;
  } ffba_sts_t;

endpackage

@@ hdl/ffba_datapath.sv @@
// Datapath: block table, alignment rounding, gap scan and result registers.
// Depends on ffba_pkg.
module ffba_datapath #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int unsigned ALIGN_BYTES  = ffba_pkg::AlignBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ffba_pkg::ffba_ctl_t       ctl_i,
  output ffba_pkg::ffba_sts_t       sts_o,
  input  logic                      cfg_we_i,
  input  logic [23:0]               cfg_data_i,
  input  logic [2:0]                command_i,
  input  logic [23:0]               object_size_i,
  input  logic [31:0]               block_id_i,
  input  logic [31:0]               ref_generation_i,
  input  logic [23:0]               ref_offset_i,
  output logic [1:0]                status_o,
  output logic [31:0]               result_id_o,
  output logic [23:0]               data_offset_o,
  output logic [31:0]               result_generation_o,
  output logic [23:0]               result_size_o
);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OW = ffba_pkg::OffW;
  localparam int unsigned EW = ffba_pkg::ExtW;
  localparam int unsigned DW = ffba_pkg::DivW;
  localparam int unsigned AL = $clog2(ALIGN_BYTES);
  localparam int unsigned MW = DW + 1;
  localparam int unsigned PW = DW + MW;
  localparam int unsigned SH = DW + AL;
  // ceil(2^SH / align): (x * RECIP) >> SH is exactly x / align for any x below 2^DW
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  logic [OW-1:0] start_q [MAX_BLOCKS];
  logic [OW-1:0] vol_q   [MAX_BLOCKS];
  logic [31:0]   ident_q [MAX_BLOCKS];

  logic [CW-1:0] count_q, idx_q;
  logic [31:0]   next_id_q, gen_q;
  logic [OW-1:0] heap_q;
  logic [2:0]    cmd_q;
  logic [OW-1:0] roff_q;
  logic [31:0]   bid_q, rgen_q;
  logic [DW-1:0] rnd_q;
  logic [PW-1:0] prod_q;
  logic [OW-1:0] new_vol_q;
  logic [EW-1:0] need_q, prev_end_q;
  logic [1:0]    status_q;
  logic [31:0]   rid_q;
  logic [OW-1:0] doff_q, rsize_q;

  logic [IW-1:0] ix;
  logic [EW-1:0] cand, limit, cur_end;
  logic [EW-1:0] vol_ext;

  assign ix       = idx_q[IW-1:0];
  assign cand     = (idx_q == '0) ? '0 : prev_end_q;
  assign limit    = (idx_q == count_q) ? EW'(heap_q) : EW'(start_q[ix]);
  assign cur_end  = EW'(start_q[ix]) + EW'(HEADER_BYTES) + EW'(vol_q[ix]);
  assign vol_ext  = EW'(prod_q[PW-1:SH]) * EW'(ALIGN_BYTES);

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (count_q == CW'(MAX_BLOCKS));
  assign sts_o.gen_match = (rgen_q == gen_q);
  assign sts_o.scan_end  = (idx_q == count_q);
  assign sts_o.fit       = (cand + need_q) <= limit;
  assign sts_o.id_hit    = (ident_q[ix] == bid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      next_id_q <= 32'd1;
      gen_q     <= 32'd1;
      heap_q    <= ffba_pkg::HeapSizeRst;
    end else begin
      if (cfg_we_i) heap_q <= cfg_data_i;
      case (ctl_i.op)
        ffba_pkg::OP_ALLOC_OK: begin
          count_q   <= count_q + 1'b1;
          next_id_q <= next_id_q + 32'd1;
        end
        ffba_pkg::OP_FREE_OK: count_q <= count_q - 1'b1;
        ffba_pkg::OP_PURGE:   count_q <= '0;
        ffba_pkg::OP_DEFRAG:  gen_q   <= gen_q + 32'd1;
        default: ;
      endcase
    end
  end

  // table shifts: every shifted entry moves from a fixed neighbor
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (ctl_i.op == ffba_pkg::OP_ALLOC_OK) begin
        if (CW'(i) == idx_q) begin
          start_q[i] <= cand[OW-1:0];
          vol_q[i]   <= new_vol_q;
          ident_q[i] <= next_id_q;
        end else if (CW'(i) > idx_q) begin
          start_q[i] <= start_q[(i + MAX_BLOCKS - 1) % MAX_BLOCKS];
          vol_q[i]   <= vol_q[(i + MAX_BLOCKS - 1) % MAX_BLOCKS];
          ident_q[i] <= ident_q[(i + MAX_BLOCKS - 1) % MAX_BLOCKS];
        end
      end else if (ctl_i.op == ffba_pkg::OP_FREE_OK) begin
        if (CW'(i) >= idx_q && i < MAX_BLOCKS - 1) begin
          start_q[i] <= start_q[(i + 1) % MAX_BLOCKS];
          vol_q[i]   <= vol_q[(i + 1) % MAX_BLOCKS];
          ident_q[i] <= ident_q[(i + 1) % MAX_BLOCKS];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ffba_pkg::OP_LOAD: begin
        cmd_q      <= command_i;
        bid_q      <= block_id_i;
        rgen_q     <= ref_generation_i;
        roff_q     <= ref_offset_i;
        rnd_q      <= DW'(object_size_i) + DW'(ALIGN_BYTES - 1);
        idx_q      <= '0;
        prev_end_q <= '0;
        status_q   <= ffba_pkg::StOk;
        rid_q      <= (command_i == ffba_pkg::CmdFree || command_i == ffba_pkg::CmdResolve)
                      ? block_id_i : '0;
        doff_q     <= '0;
        rsize_q    <= (command_i == ffba_pkg::CmdAlloc) ? object_size_i : '0;
      end
      ffba_pkg::OP_DIV: begin
        // rounding quotient by reciprocal multiplication
        prod_q <= PW'(rnd_q) * PW'(RECIP);
      end
      ffba_pkg::OP_NEED: begin
        new_vol_q <= OW'(vol_ext);
        need_q    <= vol_ext + EW'(HEADER_BYTES);
      end
      ffba_pkg::OP_SCAN: begin
        idx_q      <= idx_q + 1'b1;
        prev_end_q <= cur_end;
      end
      ffba_pkg::OP_ALLOC_OK: begin
        rid_q  <= next_id_q;
        doff_q <= OW'(cand + EW'(HEADER_BYTES));
      end
      ffba_pkg::OP_RES_OK:  doff_q <= OW'(EW'(start_q[ix]) + EW'(HEADER_BYTES));
      ffba_pkg::OP_RES_REF: doff_q <= roff_q;
      ffba_pkg::OP_FAIL: begin
        status_q <= ctl_i.status;
        if (cmd_q == ffba_pkg::CmdAlloc) rid_q <= '0;
      end
      default: ;
    endcase
  end

  assign status_o            = status_q;
  assign result_id_o         = rid_q;
  assign data_offset_o       = doff_q;
  assign result_generation_o = gen_q;
  assign result_size_o       = rsize_q;
endmodule

@@ hdl/ffba_ctrl.sv @@
// Controller state machine: sequences the datapath for each request.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_ctl_t ctl_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d      = state_q;
    ctl_o.op     = ffba_pkg::OP_NONE;
    ctl_o.status = ffba_pkg::StOk;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = ffba_pkg::OP_LOAD;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        case (sts_i.cmd)
          ffba_pkg::CmdAlloc: begin
            if (sts_i.full) begin
              ctl_o.op     = ffba_pkg::OP_FAIL;
              ctl_o.status = ffba_pkg::StFull;
            end else begin
              state_d = S_DIV;
            end
          end
          ffba_pkg::CmdFree: state_d = S_SCAN;
          ffba_pkg::CmdResolve: begin
            if (sts_i.gen_match) ctl_o.op = ffba_pkg::OP_RES_REF;
            else                 state_d  = S_SCAN;
          end
          ffba_pkg::CmdPurge:  ctl_o.op = ffba_pkg::OP_PURGE;
          ffba_pkg::CmdDefrag: ctl_o.op = ffba_pkg::OP_DEFRAG;
          default: ;
        endcase
      end
      S_DIV: begin
        ctl_o.op = ffba_pkg::OP_DIV;
        state_d  = S_PREP;
      end
      S_PREP: begin
        ctl_o.op = ffba_pkg::OP_NEED;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.cmd == ffba_pkg::CmdAlloc) begin
          if (sts_i.fit) begin
            ctl_o.op = ffba_pkg::OP_ALLOC_OK;
            state_d  = S_OUT;
          end else if (sts_i.scan_end) begin
            ctl_o.op     = ffba_pkg::OP_FAIL;
            ctl_o.status = ffba_pkg::StNoSpace;
            state_d      = S_OUT;
          end else begin
            ctl_o.op = ffba_pkg::OP_SCAN;
          end
        end else begin
          if (sts_i.scan_end) begin
            ctl_o.op     = ffba_pkg::OP_FAIL;
            ctl_o.status = ffba_pkg::StNotFound;
            state_d      = S_OUT;
          end else if (sts_i.id_hit) begin
            ctl_o.op = (sts_i.cmd == ffba_pkg::CmdFree) ? ffba_pkg::OP_FREE_OK
                                                        : ffba_pkg::OP_RES_OK;
            state_d  = S_OUT;
          end else begin
            ctl_o.op = ffba_pkg::OP_SCAN;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ hdl/first_fit_block_allocator.sv @@
// First-fit block allocator. One request at a time. Purge, defrag, unknown
// commands, allocate into a full table and resolve with a current generation
// go from acceptance through the execute state to the result; free and resolve
// by lookup scan the table in order until the matching id or the end of the
// used entries; allocate first does a reciprocal multiply step and a size
// step, then checks the gaps in address order and takes the first that fits.
// The result is held until taken; the next request is accepted the cycle
// after. heap_size writes are taken any time.
// Depends on ffba_pkg, ffba_ctrl, ffba_datapath and the macros header.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int unsigned ALIGN_BYTES  = ffba_pkg::AlignBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [23:0] object_size_i,
  input  logic [31:0] block_id_i,
  input  logic [31:0] ref_generation_i,
  input  logic [23:0] ref_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] result_id_o,
  output logic [23:0] data_offset_o,
  output logic [31:0] result_generation_o,
  output logic [23:0] result_size_o
);
  ffba_pkg::ffba_ctl_t ctl;
  ffba_pkg::ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ffba_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (command_i),
    .object_size_i       (object_size_i),
    .block_id_i          (block_id_i),
    .ref_generation_i    (ref_generation_i),
    .ref_offset_i        (ref_offset_i),
    .status_o            (status_o),
    .result_id_o         (result_id_o),
    .data_offset_o       (data_offset_o),
    .result_generation_o (result_generation_o),
    .result_size_o       (result_size_o)
  );

  `FFBA_ASSERT_IMP(a_busy_while_out, out_valid_o, in_stall_o, "result shown while idle")
  `FFBA_ASSERT_NXT(a_no_instant_result, in_valid_i && !in_stall_o, !out_valid_o, "result too early")
  `FFBA_ASSERT_NXT(a_single_result, out_valid_o && !out_stall_i, !out_valid_o, "result repeated")
endmodule

@@ dv/first_fit_block_allocator_tb.sv @@
// Self-checking testbench for first_fit_block_allocator: a table model
// predicts each response; directed and random requests are sent and stalls are randomized.
// Depends on ffba_pkg and the first_fit_block_allocator RTL.
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

  localparam int unsigned NBLK = 16;
  localparam int unsigned HDR  = 32;
  localparam int unsigned ALN  = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [23:0] offset;
    logic [31:0] gen;
    logic [23:0] size;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [23:0] object_size_i = '0;
  logic [31:0] block_id_i = '0;
  logic [31:0] ref_generation_i = '0;
  logic [23:0] ref_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] result_id_o;
  logic [23:0] data_offset_o;
  logic [31:0] result_generation_o;
  logic [23:0] result_size_o;

  first_fit_block_allocator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .command_i, .object_size_i, .block_id_i, .ref_generation_i, .ref_offset_i,
    .out_valid_o, .out_stall_i, .status_o, .result_id_o, .data_offset_o,
    .result_generation_o, .result_size_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // shadow allocator state
  logic [23:0] heap_bytes;
  logic [23:0] blk_start [NBLK];
  logic [23:0] blk_vol [NBLK];
  logic [31:0] blk_id [NBLK];
  int unsigned blk_cnt;
  logic [31:0] id_next;
  logic [31:0] heap_gen;

  resp_t expected_resp [$];
  int errors = 0;
  int burst_left = 0;

  function automatic resp_t predict_alloc(logic [2:0] cmd, logic [23:0] sz, logic [31:0] bid,
                                          logic [31:0] rgen, logic [23:0] roff);
    resp_t r;
    longint vol, need, cand, lim;
    int pos, k;
    r = '0;
    if (cmd == ffba_pkg::CmdAlloc) begin
      r.size = sz;
      vol = ((longint'(sz) + ALN - 1) / ALN) * ALN;
      need = vol + HDR;
      if (blk_cnt >= NBLK) r.status = ffba_pkg::StFull;
      else begin
        pos = -1;
        for (int i = 0; i <= blk_cnt && pos < 0; i++) begin
          cand = (i == 0) ? 0 : longint'(blk_start[i-1]) + HDR + blk_vol[i-1];
          lim = (i < blk_cnt) ? longint'(blk_start[i]) : longint'(heap_bytes);
          if (cand + need <= lim) pos = i;
        end
        if (pos < 0) r.status = ffba_pkg::StNoSpace;
        else begin
          cand = (pos == 0) ? 0 : longint'(blk_start[pos-1]) + HDR + blk_vol[pos-1];
          for (int i = blk_cnt; i > pos; i--) begin
            blk_start[i] = blk_start[i-1];
            blk_vol[i] = blk_vol[i-1];
            blk_id[i] = blk_id[i-1];
          end
          blk_start[pos] = cand[23:0];
          blk_vol[pos] = vol[23:0];
          blk_id[pos] = id_next;
          blk_cnt++;
          r.id = id_next;
          r.offset = 24'(cand + HDR);
          id_next++;
        end
      end
    end else if (cmd == ffba_pkg::CmdFree || cmd == ffba_pkg::CmdResolve) begin
      r.id = bid;
      k = -1;
      for (int i = 0; i < blk_cnt && k < 0; i++) if (blk_id[i] == bid) k = i;
      if (cmd == ffba_pkg::CmdResolve && rgen == heap_gen) r.offset = roff;
      else if (k < 0) r.status = ffba_pkg::StNotFound;
      else if (cmd == ffba_pkg::CmdResolve) r.offset = 24'(longint'(blk_start[k]) + HDR);
      else begin
        for (int i = k; i + 1 < blk_cnt; i++) begin
          blk_start[i] = blk_start[i+1];
          blk_vol[i] = blk_vol[i+1];
          blk_id[i] = blk_id[i+1];
        end
        blk_cnt--;
      end
    end else if (cmd == ffba_pkg::CmdPurge) blk_cnt = 0;
    else if (cmd == ffba_pkg::CmdDefrag) heap_gen++;
    r.gen = heap_gen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic send_request(logic [2:0] cmd, logic [23:0] sz, logic [31:0] bid,
                              logic [31:0] rgen, logic [23:0] roff);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    object_size_i <= sz;
    block_id_i <= bid;
    ref_generation_i <= rgen;
    ref_offset_i <= roff;
    do @(posedge clk_i); while (in_stall_o);
    expected_resp.push_back(predict_alloc(cmd, sz, bid, rgen, roff));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_resp.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_heap(logic [23:0] v);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    heap_bytes = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // pick an id that usually exists
  function automatic logic [31:0] pick_id();
    if (blk_cnt != 0 && $urandom_range(0, 3) != 0)
      return blk_id[$urandom_range(0, blk_cnt - 1)];
    return (($urandom_range(0, 1) != 0) ? id_next - $urandom_range(0, 40) : $urandom());
  endfunction

  function automatic logic [23:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 64));
      1: return 24'($urandom());
      default: return 24'($urandom_range(0, heap_bytes / 6 + 1));
    endcase
  endfunction

  task automatic test_directed();
    send_request(ffba_pkg::CmdResolve, 24'd5, 32'd9, 32'd7, 24'd3);
    send_request(ffba_pkg::CmdFree, '0, 32'd1, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd1, '0, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'hFFFFFF, '0, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd32, '0, '0, '0);
    send_request(ffba_pkg::CmdResolve, '0, 32'd2, 32'd1, 24'hFFFFFF);
    send_request(ffba_pkg::CmdFree, '0, 32'd1, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    send_request(ffba_pkg::CmdDefrag, '0, '0, '0, '0);
    send_request(ffba_pkg::CmdResolve, '0, 32'd2, 32'hFFFFFFFF, 24'd0);
    send_request(ffba_pkg::CmdResolve, '0, 32'hFFFFFFFF, 32'd0, 24'd0);
    send_request(3'd5, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send_request(3'd7, '0, '0, '0, '0);
    send_request(3'd6, '0, '0, '0, '0);
    for (int i = 0; i < 18; i++) send_request(ffba_pkg::CmdAlloc, 24'd1, '0, '0, '0);
    send_request(ffba_pkg::CmdPurge, '0, '0, '0, '0);
  endtask

  task automatic test_heap_extremes();
    set_heap(24'd0);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    set_heap(24'd32);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    set_heap(24'hFFFFFF);
    send_request(ffba_pkg::CmdAlloc, 24'hFFFFDF, '0, '0, '0);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    set_heap(24'd2048);
    send_request(ffba_pkg::CmdAlloc, 24'd0, '0, '0, '0);
    send_request(ffba_pkg::CmdPurge, '0, '0, '0, '0);
  endtask

  task automatic test_random(int n, logic [23:0] heap);
    int c;
    set_heap(heap);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 45)
        send_request(ffba_pkg::CmdAlloc, pick_size(), $urandom(), $urandom(),
                     24'($urandom()));
      else if (c < 75)
        send_request(ffba_pkg::CmdFree, 24'($urandom()), pick_id(), $urandom(),
                     24'($urandom()));
      else if (c < 92)
        send_request(ffba_pkg::CmdResolve, 24'($urandom()), pick_id(),
                     ($urandom_range(0, 1) != 0) ? heap_gen : $urandom(), 24'($urandom()));
      else if (c < 94)
        send_request(ffba_pkg::CmdPurge, 24'($urandom()), $urandom(), $urandom(),
                     24'($urandom()));
      else if (c < 98)
        send_request(ffba_pkg::CmdDefrag, 24'($urandom()), $urandom(), $urandom(),
                     24'($urandom()));
      else
        send_request(3'($urandom_range(5, 7)), 24'($urandom()), $urandom(), $urandom(),
                     24'($urandom()));
    end
  endtask

  // response checker with its own stall pattern
  always @(posedge clk_i) begin
    resp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_resp.size() == 0) report_mismatch("unexpected response", '0, '0);
      else begin
        w = expected_resp.pop_front();
        if (status_o !== w.status)
          report_mismatch("status", 32'(status_o), 32'(w.status));
        if (result_id_o !== w.id) report_mismatch("result_id", result_id_o, w.id);
        if (data_offset_o !== w.offset)
          report_mismatch("data_offset", 32'(data_offset_o), 32'(w.offset));
        if (result_generation_o !== w.gen)
          report_mismatch("result_generation", result_generation_o, w.gen);
        if (result_size_o !== w.size)
          report_mismatch("result_size", 32'(result_size_o), 32'(w.size));
      end
    end
    out_stall_i <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 999) > 300);
  end

  initial begin
    heap_bytes = ffba_pkg::HeapSizeRst;
    blk_cnt = 0;
    id_next = 32'd1;
    heap_gen = 32'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_heap_extremes();
    test_random(500, 24'd4096);
    test_random(400, ffba_pkg::HeapSizeRst);
    test_random(300, 24'd700);
    test_random(300, 24'hFFFFFF);
    test_random(100, 24'd300);
    wait_drain();
    if (errors == 0) $display("first_fit_block_allocator_tb: PASS");
    else $display("first_fit_block_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("first_fit_block_allocator_tb: FAIL");
    $finish;
  end

endmodule
